[design/fthrt_pkg.sv]
// package: widths and constants of the half round trip converter
`default_nettype none
package fthrt_pkg;
    localparam logic [15:0] HalfInf = 16'h7c00;
    localparam logic [15:0] HalfQnan = 16'h7e00;
    localparam logic [12:0] TiePoint = 13'h1000;
    localparam logic [10:0] HalfHidden = 11'h400;
    localparam logic [7:0] ExpRebias = 8'd112;
    localparam logic [31:0] SingleInf = 32'h7f800000;
endpackage
`default_nettype wire

[design/fthrt_if.sv]
// stream interfaces for input and result items
`default_nettype none
interface fthrt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] single_bits;
    modport source (output valid, output single_bits, input ready);
    modport sink (input valid, input single_bits, output ready);
endinterface

interface fthrt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] half_bits;
    logic [31:0] widened_bits;
    modport source (output valid, output half_bits, output widened_bits, input ready);
    modport sink (input valid, input half_bits, input widened_bits, output ready);
endinterface
`default_nettype wire

[design/fthrt_lzc.sv]
// leading zero count of a ten bit half subnormal fraction
`default_nettype none
module fthrt_lzc (
    input  wire logic [9:0] i_frac,
    output logic [3:0]      o_count
);
    // priority search from the msb
    always_comb begin
        o_count = 4'd10;
        for (int k = 0; k < 10; k++) begin
            if (i_frac[k]) o_count = 4'(9 - k);
        end
    end
endmodule
`default_nettype wire

[design/float_to_half_round_trip.sv]
// top level: binary32 to binary16 round to nearest even and exact widening back
//
//  channel  dir  payload                        handshake
//  i_in     in   single_bits[31:0]              valid/ready
//  o_out    out  half_bits[15:0], widened[31:0] valid/ready
//
// four register stages: decode, round, pack half, widen; one item per cycle while the output is not stalled
// an accepted item passes through the decode, round, pack half and widen registers in order before it is a valid result
// synchronous active low reset clears the stage valid bits
// a stage advances when it is empty or the one after it advances, so a
// stall holds each item in place with nothing lost or repeated
`default_nettype none
module float_to_half_round_trip (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fthrt_in_if.sink    i_in,
    fthrt_out_if.source o_out
);
    // stage valid bits and advance enables
    logic [3:0] r_vld;
    logic [3:0] adv;
    assign adv[3] = !r_vld[3] || o_out.ready;
    assign adv[2] = !r_vld[2] || adv[3];
    assign adv[1] = !r_vld[1] || adv[2];
    assign adv[0] = !r_vld[0] || adv[1];
    assign i_in.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_in.valid;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
            if (adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    // stage 1: classify and align significand
    typedef enum logic [1:0] {K_ZERO, K_INF, K_NAN, K_FIN} t_kind;
    logic        r1_sgn;
    t_kind       r1_kind;
    logic        r1_sub;
    logic [4:0]  r1_he;
    logic [10:0] r1_q;
    logic [23:0] r1_rem;
    logic [23:0] r1_tie;
    t_kind       n1_kind;
    logic        n1_sub;
    logic [4:0]  n1_he;
    logic [10:0] n1_q;
    logic [23:0] n1_rem;
    logic [23:0] n1_tie;
    logic [7:0]  e_in;
    logic [22:0] m_in;
    logic [23:0] full;
    logic [4:0]  sh;
    assign e_in = i_in.single_bits[30:23];
    assign m_in = i_in.single_bits[22:0];
    assign full = {1'b1, m_in};
    assign sh = 5'(8'd126 - e_in);

    always_comb begin
        n1_kind = K_FIN;
        n1_sub = 1'b0;
        n1_he = 5'(e_in - fthrt_pkg::ExpRebias);
        n1_q = {1'b0, m_in[22:13]};
        n1_rem = {11'd0, m_in[12:0]};
        n1_tie = {11'd0, fthrt_pkg::TiePoint};
        if (e_in == 8'hff) begin
            n1_kind = (m_in == '0) ? K_INF : K_NAN;
        end else if (e_in == 8'd0 || e_in < 8'd102) begin
            n1_kind = K_ZERO;
        end else if (e_in >= 8'd143) begin
            n1_kind = K_INF;
        end else if (e_in <= fthrt_pkg::ExpRebias) begin
            n1_sub = 1'b1;
            n1_q = 11'(full >> sh);
            n1_rem = full & ((24'd1 << sh) - 24'd1);
            n1_tie = 24'd1 << (sh - 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_sgn <= i_in.single_bits[31];
            r1_kind <= n1_kind;
            r1_sub <= n1_sub;
            r1_he <= n1_he;
            r1_q <= n1_q;
            r1_rem <= n1_rem;
            r1_tie <= n1_tie;
        end
    end

    // stage 2: round to nearest even
    logic        r2_sgn;
    t_kind       r2_kind;
    logic        r2_sub;
    logic [4:0]  r2_he;
    logic [10:0] r2_q;
    logic        up;
    assign up = (r1_rem > r1_tie) || (r1_rem == r1_tie && r1_q[0]);
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_sgn <= r1_sgn;
            r2_kind <= r1_kind;
            r2_sub <= r1_sub;
            r2_he <= r1_he;
            r2_q <= r1_q + 11'(up);
        end
    end

    // stage 3: pack the half
    logic [15:0] r3_half;
    logic [15:0] n3_half;
    logic [5:0]  he_c;
    always_comb begin
        he_c = {1'b0, r2_he} + 6'(r2_q[10]);
        case (r2_kind)
            K_ZERO:  n3_half = {r2_sgn, 15'd0};
            K_INF:   n3_half = {r2_sgn, fthrt_pkg::HalfInf[14:0]};
            K_NAN:   n3_half = {r2_sgn, fthrt_pkg::HalfQnan[14:0]};
            default: begin
                if (r2_sub) begin
                    n3_half = {r2_sgn, 5'(r2_q[10]), r2_q[9:0]};
                end else if (he_c >= 6'd31) begin
                    n3_half = {r2_sgn, fthrt_pkg::HalfInf[14:0]};
                end else begin
                    n3_half = {r2_sgn, he_c[4:0], r2_q[9:0]};
                end
            end
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (adv[2]) r3_half <= n3_half;
    end

    // stage 4: widen back with renormalization of subnormals
    logic [15:0] r4_half;
    logic [31:0] r4_wide;
    logic [31:0] n4_wide;
    logic [3:0]  lz;
    logic [4:0]  h_e;
    logic [9:0]  h_m;
    logic [9:0]  norm;
    assign h_e = r3_half[14:10];
    assign h_m = r3_half[9:0];
    fthrt_lzc u_lzc (.i_frac(h_m), .o_count(lz));
    assign norm = 10'({h_m, 1'b0} << lz);
    always_comb begin
        if (h_e == 5'd0) begin
            if (h_m == '0) n4_wide = {r3_half[15], 31'd0};
            else n4_wide = {r3_half[15], 8'(8'd113 - 8'(lz) - 8'd1), norm, 13'd0};
        end else if (h_e == 5'h1f) begin
            n4_wide = {r3_half[15], fthrt_pkg::SingleInf[30:23], h_m, 13'd0};
        end else begin
            n4_wide = {r3_half[15], 8'({3'd0, h_e} + fthrt_pkg::ExpRebias), h_m, 13'd0};
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r4_half <= r3_half;
            r4_wide <= n4_wide;
        end
    end

    assign o_out.valid = r_vld[3];
    assign o_out.half_bits = r4_half;
    assign o_out.widened_bits = r4_wide;

    // checks
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(r4_wide))
        else $error("result lost under stall");
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.half_bits[15] == o_out.widened_bits[31])
        else $error("sign mismatch");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[3] |-> i_in.ready || r_vld[2] == 1'b1)
        else $error("pipeline bubble blocks input");
endmodule
`default_nettype wire
